// ===== design/nsi_pkg.sv =====
package nsi_pkg;

  localparam int unsigned ValueW = 64;

  // configuration register indexes
  localparam logic CFG_BASE_SELECT = 1'b0;
  localparam logic CFG_RESULT_SIZE = 1'b1;

  // base_select codes
  localparam logic [4:0] SEL_AUTO = 5'd0;
  localparam logic [4:0] SEL_BIN  = 5'd2;
  localparam logic [4:0] SEL_DEC  = 5'd10;
  localparam logic [4:0] SEL_HEX  = 5'd16;

  // latched radix
  localparam logic [1:0] BASE_NONE = 2'd0;
  localparam logic [1:0] BASE_BIN  = 2'd1;
  localparam logic [1:0] BASE_DEC  = 2'd2;
  localparam logic [1:0] BASE_HEX  = 2'd3;

  // character position
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_LATER  = 2'd2;

  localparam logic [1:0] SIZE_RESET = 2'd3;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_OFS = 8'h37;  // '7'
  localparam logic [7:0] CH_LC_OFS = 8'h57;  // 'W'
  localparam logic [7:0] CH_PFX_B  = 8'h62;  // 'b'
  localparam logic [7:0] CH_PFX_X  = 8'h78;  // 'x'

  localparam logic [4:0] DIGIT_BAD = 5'd16;

  localparam logic [ValueW-1:0] WMAX_8  = 64'h0000_0000_0000_00FF;
  localparam logic [ValueW-1:0] WMAX_16 = 64'h0000_0000_0000_FFFF;
  localparam logic [ValueW-1:0] WMAX_32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [ValueW-1:0] WMAX_64 = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [3:0][ValueW-1:0] WIDTH_MAX = {WMAX_64, WMAX_32, WMAX_16, WMAX_8};
  localparam logic [3:0][ValueW-1:0] DEC_LIMIT =
    {WMAX_64 / 10, WMAX_32 / 10, WMAX_16 / 10, WMAX_8 / 10};

  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic [1:0]        pos;
    logic [1:0]        base;
    logic              seen;
    logic              failed;
  } nsi_state_t;

  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] base);
    logic [4:0] d;
    d = DIGIT_BAD;
    case (base)
      BASE_BIN: begin
        if (c inside {CH_ZERO, CH_ONE}) d = 5'(c - CH_ZERO);
      end
      BASE_DEC: begin
        if (c inside {[CH_ZERO:CH_NINE]}) d = 5'(c - CH_ZERO);
      end
      BASE_HEX: begin
        if (c inside {[CH_ZERO:CH_NINE]}) d = 5'(c - CH_ZERO);
        else if (c inside {[CH_UC_A:CH_UC_F]}) d = 5'(c - CH_UC_OFS);
        else if (c inside {[CH_LC_A:CH_LC_F]}) d = 5'(c - CH_LC_OFS);
      end
      default: d = DIGIT_BAD;
    endcase
    return d;
  endfunction

  // largest accumulator that can still take one more digit
  function automatic logic [ValueW-1:0] pre_limit(input logic [1:0] size,
                                                   input logic [1:0] base);
    logic [ValueW-1:0] lim;
    case (base)
      BASE_BIN: lim = WIDTH_MAX[size] >> 1;
      BASE_DEC: lim = DEC_LIMIT[size];
      default:  lim = WIDTH_MAX[size] >> 4;
    endcase
    return lim;
  endfunction

endpackage

// ===== design/nsi_step.sv =====
module nsi_step (
  input  nsi_pkg::nsi_state_t st,
  input  logic [7:0]          ch,
  input  logic                last,
  input  logic [4:0]          base_select,
  input  logic [1:0]          result_size,
  output nsi_pkg::nsi_state_t st_nxt,
  output logic [63:0]         res_value,
  output logic                res_ok
);

  logic [1:0]  base;
  logic        fail;
  logic        digit_en;
  logic [4:0]  d;
  logic [63:0] mx;
  logic [63:0] prod;
  logic [63:0] acc;
  logic        seen;

  always_comb begin
    fail     = st.failed;
    base     = st.base;
    digit_en = 1'b0;
    if (!st.failed) begin
      if (st.pos == nsi_pkg::POS_FIRST) begin
        if (base_select == nsi_pkg::SEL_AUTO) begin
          if (last) begin
            fail = 1'b1;
          end else if (ch != nsi_pkg::CH_ZERO) begin
            base     = nsi_pkg::BASE_DEC;
            digit_en = 1'b1;
          end
        end else begin
          case (base_select)
            nsi_pkg::SEL_BIN: base = nsi_pkg::BASE_BIN;
            nsi_pkg::SEL_DEC: base = nsi_pkg::BASE_DEC;
            nsi_pkg::SEL_HEX: base = nsi_pkg::BASE_HEX;
            default:          fail = 1'b1;
          endcase
          digit_en = !fail;
        end
      end else if (st.base == nsi_pkg::BASE_NONE) begin
        if (st.pos != nsi_pkg::POS_SECOND) begin
          fail = 1'b1;
        end else if (ch == nsi_pkg::CH_PFX_B) begin
          base = nsi_pkg::BASE_BIN;
        end else if (ch == nsi_pkg::CH_PFX_X) begin
          base = nsi_pkg::BASE_HEX;
        end else begin
          base     = nsi_pkg::BASE_DEC;
          digit_en = 1'b1;
        end
      end else begin
        digit_en = 1'b1;
      end
    end
  end

  always_comb begin
    d  = nsi_pkg::digit_of(ch, base);
    mx = nsi_pkg::WIDTH_MAX[result_size];
    case (base)
      nsi_pkg::BASE_BIN: prod = {st.acc[62:0], 1'b0};
      nsi_pkg::BASE_DEC: prod = {st.acc[60:0], 3'b000} + {st.acc[62:0], 1'b0};
      default:           prod = {st.acc[59:0], 4'b0000};
    endcase
  end

  always_comb begin
    st_nxt    = st;
    acc       = st.acc;
    seen      = st.seen;
    st_nxt.failed = fail;
    st_nxt.base   = base;
    if (digit_en) begin
      if (d[4] || (st.acc > nsi_pkg::pre_limit(result_size, base))) begin
        st_nxt.failed = 1'b1;
      end else if (prod > (mx - {59'd0, d})) begin
        st_nxt.failed = 1'b1;
      end else begin
        acc  = prod + {59'd0, d};
        seen = 1'b1;
      end
    end
    st_nxt.acc  = acc;
    st_nxt.seen = seen;
    if (st.pos != nsi_pkg::POS_LATER) begin
      st_nxt.pos = st.pos + 2'd1;
    end
    res_ok    = !st_nxt.failed && seen;
    res_value = res_ok ? acc : 64'd0;
    if (last) begin
      st_nxt = '0;
    end
  end

endmodule

// ===== design/numeric_string_to_integer_core.sv =====
// Streaming string-to-unsigned converter. Feed one character per item with
// in_last on the final one; exactly one result (out_value, out_ok) follows
// each string. Base (2, 10, 16, or 0 for "0b"/"0x"/decimal detection) and
// result width (1/2/4/8 bytes) come from the two cfg registers and must be
// written between strings. Throughput is one character per cycle; a result
// is registered once its last character is taken (input register, then
// one pass through the digit/overflow logic into the result register).
// The only stall on the input comes from a held result meeting the next
// string's last character.
module numeric_string_to_integer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic        out_ok,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);

  logic                s1_valid_r;
  logic [7:0]          s1_ch_r;
  logic                s1_last_r;
  nsi_pkg::nsi_state_t st_r;
  nsi_pkg::nsi_state_t st_nxt;
  logic [4:0]          base_select_r;
  logic [1:0]          result_size_r;
  logic                out_valid_r;
  logic [63:0]         out_value_r;
  logic                out_ok_r;
  logic [63:0]         res_value;
  logic                res_ok;
  logic                advance;

  assign advance  = s1_valid_r && !(s1_last_r && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !advance;

  nsi_step u_step (
    .st          (st_r),
    .ch          (s1_ch_r),
    .last        (s1_last_r),
    .base_select (base_select_r),
    .result_size (result_size_r),
    .st_nxt      (st_nxt),
    .res_value   (res_value),
    .res_ok      (res_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_select_r <= nsi_pkg::SEL_AUTO;
      result_size_r <= nsi_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        nsi_pkg::CFG_BASE_SELECT: base_select_r <= cfg_wdata;
        nsi_pkg::CFG_RESULT_SIZE: result_size_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_value_r <= res_value;
      out_ok_r    <= res_ok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_ok    = out_ok_r;

endmodule

// ===== design/nsi_checker.sv =====
module nsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_value,
  input logic        out_ok
);

  // a failed conversion reports zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_value == 64'd0)
    else $error("failed result carries a non-zero value");

  // a string's end taken with the output free yields a result
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last && !out_valid |=> ##1 out_valid)
    else $error("no result after final character");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_ok))
    else $error("stalled result changed");

endmodule

bind numeric_string_to_integer_core nsi_checker u_nsi_checker (.*);
